/* rtl/ppe_pkg.sv */
package ppe_pkg;

  // Per-slot record as kept in the slot memory.
  typedef struct packed {
    logic signed [16:0] life;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic        [15:0] size_x;
    logic        [15:0] size_y;
    logic        [31:0] tint;
  } ppe_entry_t;

  localparam int ENTRY_W = $bits(ppe_entry_t);

  // One result beat.
  typedef struct packed {
    logic        [1:0]  record_kind;
    logic        [4:0]  slot_index;
    logic signed [23:0] place_x;
    logic signed [23:0] place_y;
    logic        [15:0] extent_x;
    logic        [15:0] extent_y;
    logic        [31:0] shade;
    logic        [15:0] texture_handle;
    logic               last_record;
  } ppe_rec_t;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_TICK = 2'd1,
    OP_DRAW = 2'd2
  } ppe_op_t;

  typedef enum logic [1:0] {
    KIND_ADD  = 2'd0,
    KIND_TICK = 2'd1,
    KIND_REC  = 2'd2,
    KIND_NONE = 2'd3
  } ppe_kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND_RD,
    S_FIND_CHK,
    S_ADD_WR,
    S_SCAN_RD,
    S_SCAN_EV,
    S_FINISH
  } ppe_state_t;

  localparam logic [1:0] REG_POOL_SIZE = 2'd0;
  localparam logic [1:0] REG_DECAY     = 2'd1;
  localparam logic [1:0] REG_TEXTURE   = 2'd2;

  localparam logic signed [16:0] LIFE_FULL = 17'sd32768;

  // Wide enough to hold a slot count up to the largest pool size register value (63).
  localparam int SLOT_CNT_W = 7;

  localparam logic [5:0]  POOL_SIZE_RST = 6'd32;
  localparam logic [15:0] DECAY_RST     = 16'd328;
  localparam logic [15:0] TEXTURE_RST   = 16'd0;

endpackage

/* rtl/ppe_chan_if.sv */
interface ppe_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  operation;
  logic signed [23:0] start_x;
  logic signed [23:0] start_y;
  logic signed [15:0] step_x;
  logic signed [15:0] step_y;
  logic        [15:0] size_x;
  logic        [15:0] size_y;
  logic        [31:0] tint;

  modport source (output valid, operation, start_x, start_y, step_x, step_y,
                  size_x, size_y, tint, input ready);
  modport sink   (input valid, operation, start_x, start_y, step_x, step_y,
                  size_x, size_y, tint, output ready);
endinterface

interface ppe_out_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  record_kind;
  logic        [4:0]  slot_index;
  logic signed [23:0] place_x;
  logic signed [23:0] place_y;
  logic        [15:0] extent_x;
  logic        [15:0] extent_y;
  logic        [31:0] shade;
  logic        [15:0] texture_handle;
  logic               last_record;

  modport source (output valid, record_kind, slot_index, place_x, place_y, extent_x,
                  extent_y, shade, texture_handle, last_record, input ready);
  modport sink   (input valid, record_kind, slot_index, place_x, place_y, extent_x,
                  extent_y, shade, texture_handle, last_record, output ready);
endinterface

/* rtl/particle_pool_engine.sv */
// Channel   Dir  Handshake            Beat contents
// in_chan   in   valid/ready          operation, start_x/y, step_x/y, size_x/y, tint
// out_chan  out  valid/ready          record_kind, slot_index, place, extent, shade, ...
// cfg_*     in   cfg_we, no wait      cfg_index selects pool size, decay, texture
//
// One item at a time; in_chan.ready is high only while idle.
// Add: each slot probed takes a read step and a check step, then one write step.
// Tick and draw: a read step and an evaluate step per slot in use (the slot memory
// read is registered), then one finish step.
// Reset is synchronous; the slot live bits clear at once, no clearing pass.
// A stalled out_chan holds the sequencer on the step that needs to emit a beat.
module particle_pool_engine #(
  parameter int POOL_SIZE = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  ppe_in_if.sink      in_chan,
  ppe_out_if.source   out_chan,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import ppe_pkg::*;

  localparam int IW = $clog2(POOL_SIZE);

  // Configuration
  logic [5:0]  pool_size_r;
  logic [15:0] decay_r;
  logic [15:0] texture_r;

  // Sequencer and slot bookkeeping
  ppe_state_t          state_r, state_nxt;
  ppe_op_t             op_r, op_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic [IW-1:0]       cnt_r, cnt_nxt;
  logic [IW-1:0]       start_r, start_nxt;
  logic                found_r, found_nxt;
  ppe_entry_t          item_r, item_nxt;
  logic                pend_valid_r, pend_valid_nxt;
  ppe_rec_t            pend_rec_r, pend_rec_nxt;
  logic                out_valid_r;
  ppe_rec_t            out_rec_r;
  logic [POOL_SIZE-1:0] valid_r;
  logic                set_valid;

  // Handshake and datapath
  logic                in_ready;
  logic                in_fire;
  logic                out_free;
  logic                push;
  ppe_rec_t            push_rec;
  logic                ram_we;
  ppe_entry_t          ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;
  ppe_entry_t          rd_entry;
  ppe_entry_t          adv_entry;
  logic                slot_live;

  logic [SLOT_CNT_W-1:0] n_use;
  logic                  n_zero;
  logic                  idx_at_end;
  logic                  cnt_at_end;
  logic [IW-1:0]         idx_wrap;
  logic [IW-1:0]         find_first;
  logic                  scan_go;
  ppe_rec_t              rd_rec;

  // ------------------------------------------------------------------
  // Configuration registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_size_r <= POOL_SIZE_RST;
      decay_r     <= DECAY_RST;
      texture_r   <= TEXTURE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POOL_SIZE: pool_size_r <= cfg_wdata[5:0];
        REG_DECAY:     decay_r     <= cfg_wdata;
        REG_TEXTURE:   texture_r   <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  // Clamp the pool in use to the physical pool.
  assign n_use  = (SLOT_CNT_W'(pool_size_r) > SLOT_CNT_W'(POOL_SIZE)) ?
                  SLOT_CNT_W'(POOL_SIZE) : SLOT_CNT_W'(pool_size_r);
  assign n_zero = (n_use == '0);

  // ------------------------------------------------------------------
  // Slot memory and the shared advance unit
  // ------------------------------------------------------------------
  ppe_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (POOL_SIZE)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  assign rd_entry = ppe_entry_t'(ram_rdata);

  ppe_adv u_adv (
    .cur       (rd_entry),
    .cur_valid (valid_r[idx_r]),
    .decay     (decay_r),
    .live      (slot_live),
    .nxt       (adv_entry)
  );

  // ------------------------------------------------------------------
  // Shared conditions
  // ------------------------------------------------------------------
  assign in_fire    = in_chan.valid && in_ready;
  assign out_free   = !out_valid_r || out_chan.ready;
  assign idx_at_end = (SLOT_CNT_W'(idx_r) == n_use - SLOT_CNT_W'(1));
  assign cnt_at_end = (SLOT_CNT_W'(cnt_r) == n_use - SLOT_CNT_W'(1));
  assign idx_wrap   = idx_at_end ? '0 : idx_r + IW'(1);
  // Pool shrank below the saved start: search from slot 0.
  assign find_first = (SLOT_CNT_W'(start_r) < n_use) ? start_r : '0;
  // A draw that finds a second live slot must hand the held one to the output.
  assign scan_go    = !(op_r == OP_DRAW && slot_live && pend_valid_r) || out_free;

  always_comb begin
    rd_rec                = '0;
    rd_rec.record_kind    = KIND_REC;
    rd_rec.slot_index     = 5'(idx_r);
    rd_rec.place_x        = rd_entry.pos_x;
    rd_rec.place_y        = rd_entry.pos_y;
    rd_rec.extent_x       = rd_entry.size_x;
    rd_rec.extent_y       = rd_entry.size_y;
    rd_rec.shade          = rd_entry.tint;
    rd_rec.texture_handle = texture_r;
    rd_rec.last_record    = 1'b0;
  end

  // ------------------------------------------------------------------
  // Sequencer: next state
  // ------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_chan.operation)
            OP_ADD:  state_nxt = n_zero ? S_ADD_WR : S_FIND_RD;
            OP_TICK,
            OP_DRAW: state_nxt = n_zero ? S_FINISH : S_SCAN_RD;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_FIND_RD:  state_nxt = S_FIND_CHK;
      S_FIND_CHK: state_nxt = (!slot_live || cnt_at_end) ? S_ADD_WR : S_FIND_RD;
      S_ADD_WR:   state_nxt = out_free ? S_IDLE : S_ADD_WR;
      S_SCAN_RD:  state_nxt = S_SCAN_EV;
      S_SCAN_EV: begin
        if (scan_go) begin
          state_nxt = idx_at_end ? S_FINISH : S_SCAN_RD;
        end
      end
      S_FINISH:   state_nxt = out_free ? S_IDLE : S_FINISH;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // ------------------------------------------------------------------
  // Sequencer: outputs and datapath updates
  // ------------------------------------------------------------------
  always_comb begin
    in_ready       = 1'b0;
    ram_we         = 1'b0;
    ram_wdata      = adv_entry;
    set_valid      = 1'b0;
    push           = 1'b0;
    push_rec       = '0;
    op_nxt         = op_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    start_nxt      = start_r;
    found_nxt      = found_r;
    item_nxt       = item_r;
    pend_valid_nxt = pend_valid_r;
    pend_rec_nxt   = pend_rec_r;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          op_nxt         = ppe_op_t'(in_chan.operation);
          item_nxt.life  = LIFE_FULL;
          item_nxt.pos_x = in_chan.start_x;
          item_nxt.pos_y = in_chan.start_y;
          item_nxt.vel_x = in_chan.step_x;
          item_nxt.vel_y = in_chan.step_y;
          item_nxt.size_x = in_chan.size_x;
          item_nxt.size_y = in_chan.size_y;
          item_nxt.tint  = in_chan.tint;
          cnt_nxt        = '0;
          found_nxt      = 1'b0;
          pend_valid_nxt = 1'b0;
          idx_nxt        = (in_chan.operation == OP_ADD && !n_zero) ? find_first : '0;
        end
      end
      S_FIND_CHK: begin
        if (!slot_live) begin
          found_nxt = 1'b1;
        end else if (cnt_at_end) begin
          // Pool full: overwrite slot 0, keep the search start.
          idx_nxt = '0;
        end else begin
          idx_nxt = idx_wrap;
          cnt_nxt = cnt_r + IW'(1);
        end
      end
      S_ADD_WR: begin
        if (out_free) begin
          ram_we               = 1'b1;
          ram_wdata            = item_r;
          set_valid            = 1'b1;
          push                 = 1'b1;
          push_rec.record_kind = KIND_ADD;
          push_rec.slot_index  = 5'(idx_r);
          push_rec.last_record = 1'b1;
          if (found_r) begin
            start_nxt = idx_r;
          end
        end
      end
      S_SCAN_EV: begin
        if (scan_go) begin
          ram_we = slot_live;
          if (op_r == OP_DRAW && slot_live) begin
            // Hold this record until we know whether it is the last one.
            if (pend_valid_r) begin
              push     = 1'b1;
              push_rec = pend_rec_r;
            end
            pend_valid_nxt = 1'b1;
            pend_rec_nxt   = rd_rec;
          end
          idx_nxt = idx_wrap;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          push           = 1'b1;
          pend_valid_nxt = 1'b0;
          if (op_r == OP_DRAW && pend_valid_r) begin
            push_rec             = pend_rec_r;
            push_rec.last_record = 1'b1;
          end else begin
            push_rec.record_kind = (op_r == OP_DRAW) ? KIND_NONE : KIND_TICK;
            push_rec.last_record = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // ------------------------------------------------------------------
  // Registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      start_r      <= '0;
      valid_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      start_r      <= start_nxt;
      pend_valid_r <= pend_valid_nxt;
      if (set_valid) begin
        valid_r[idx_r] <= 1'b1;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    idx_r      <= idx_nxt;
    cnt_r      <= cnt_nxt;
    found_r    <= found_nxt;
    item_r     <= item_nxt;
    pend_rec_r <= pend_rec_nxt;
    if (push) begin
      out_rec_r <= push_rec;
    end
  end

  // ------------------------------------------------------------------
  // Ports
  // ------------------------------------------------------------------
  assign in_chan.ready           = in_ready;
  assign out_chan.valid          = out_valid_r;
  assign out_chan.record_kind    = out_rec_r.record_kind;
  assign out_chan.slot_index     = out_rec_r.slot_index;
  assign out_chan.place_x        = out_rec_r.place_x;
  assign out_chan.place_y        = out_rec_r.place_y;
  assign out_chan.extent_x       = out_rec_r.extent_x;
  assign out_chan.extent_y       = out_rec_r.extent_y;
  assign out_chan.shade          = out_rec_r.shade;
  assign out_chan.texture_handle = out_rec_r.texture_handle;
  assign out_chan.last_record    = out_rec_r.last_record;

`ifndef SYNTHESIS
  a_write_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (SLOT_CNT_W'(idx_r) < n_use) || (n_zero && idx_r == '0))
    else $error("slot write outside the pool in use");

  a_pend_only_draw: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (op_r == OP_DRAW))
    else $error("held draw record outside a draw");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> out_free)
    else $error("beat pushed over an unaccepted beat");

  a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && out_free) |=> (!pend_valid_r && state_r == S_IDLE))
    else $error("finish left a held record or did not return to idle");

  a_none_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rec_r.record_kind != KIND_REC) |-> out_rec_r.last_record)
    else $error("single-beat result without last flag");
`endif

endmodule

/* rtl/ppe_ram.sv */
module ppe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/ppe_adv.sv */
module ppe_adv (
  input  ppe_pkg::ppe_entry_t cur,
  input  logic                cur_valid,
  input  logic [15:0]         decay,
  output logic                live,
  output ppe_pkg::ppe_entry_t nxt
);
  import ppe_pkg::*;

  logic signed [24:0] sum_x;
  logic signed [24:0] sum_y;
  logic        [17:0] life_d;

  // Saturate a 25-bit sum back into the 24-bit position range.
  function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
    logic signed [23:0] r;
    if (v[24] != v[23]) begin
      r = v[24] ? 24'sh800000 : 24'sh7FFFFF;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  assign live   = cur_valid && (cur.life > 17'sd0);
  assign sum_x  = 25'(cur.pos_x) + 25'(cur.vel_x);
  assign sum_y  = 25'(cur.pos_y) + 25'(cur.vel_y);
  assign life_d = 18'(cur.life) - 18'(decay);

  always_comb begin
    nxt       = cur;
    nxt.pos_x = sat24(sum_x);
    nxt.pos_y = sat24(sum_y);
    nxt.life  = life_d[16:0];
  end

endmodule
